// ===== sv/fragment_reassembly_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// fragment reassembly deframer assertion macros
// implication checks on the rising clock edge, off while in reset
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_REASSEMBLY_DEFRAMER_MACROS_SVH
`define FRAGMENT_REASSEMBLY_DEFRAMER_MACROS_SVH

// same-cycle implication
`define FRD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frd assertion failed");

// next-cycle implication
`define FRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frd assertion failed");

`endif

// ===== sv/frd_pkg.sv =====
// ----------------------------------------------------------------------------
// frd_pkg
// shared types and constants of the fragment reassembly deframer
// ----------------------------------------------------------------------------
package frd_pkg;

    localparam int DEF_PAYLOAD_BYTES = 29;
    localparam int BYTE_W            = 8;
    localparam int NIB_W             = 4;
    localparam int ADDR_W            = 9;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_DROP  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  write_addr;
        logic [BYTE_W-1:0]  data_byte;
        logic               message_done;
        logic [ADDR_W-1:0]  message_len;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

endpackage

// ===== sv/frd_byte_if.sv =====
// ----------------------------------------------------------------------------
// frd_byte_if
// received link byte channel with valid and ready
// ----------------------------------------------------------------------------
interface frd_byte_if;
    logic                      valid;
    logic                      ready;
    logic [frd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/frd_result_if.sv =====
// ----------------------------------------------------------------------------
// frd_result_if
// result channel: payload writes and fragment drops
// ----------------------------------------------------------------------------
interface frd_result_if;
    logic                       valid;
    logic                       ready;
    frd_pkg::t_kind             kind;
    logic [frd_pkg::ADDR_W-1:0] write_addr;
    logic [frd_pkg::BYTE_W-1:0] data_byte;
    logic                       message_done;
    logic [frd_pkg::ADDR_W-1:0] message_len;

    modport source (output valid, output kind, output write_addr, output data_byte,
                    output message_done, output message_len, input ready);
    modport sink   (input valid, input kind, input write_addr, input data_byte,
                    input message_done, input message_len, output ready);
endinterface

// ===== sv/frd_ctrl.sv =====
// ----------------------------------------------------------------------------
// frd_ctrl
// frame position tracking, header check and per-byte result generation
// ----------------------------------------------------------------------------
`include "fragment_reassembly_deframer_macros.svh"

module frd_ctrl #(
    parameter int PAYLOAD_BYTES = frd_pkg::DEF_PAYLOAD_BYTES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic [frd_pkg::BYTE_W-1:0] i_byte,
    output frd_pkg::t_push             o_push
);

    localparam int POS_W = $clog2(PAYLOAD_BYTES + 2);
    localparam logic [POS_W-1:0] FRAME_LAST = POS_W'(PAYLOAD_BYTES + 1);
    localparam logic [POS_W-1:0] PAY_LAST   = POS_W'(PAYLOAD_BYTES);
    localparam int ADDR_W = frd_pkg::ADDR_W;
    localparam int NIB_W  = frd_pkg::NIB_W;

    logic [POS_W-1:0]  r_pos,        n_pos;
    logic              r_accepted,   n_accepted;
    logic              r_last_valid, n_last_valid;
    logic [NIB_W-1:0]  r_last_index, n_last_index;
    logic [ADDR_W-1:0] r_addr,       n_addr;
    logic              r_final,      n_final;
    logic [ADDR_W-1:0] r_len,        n_len;

    logic [NIB_W-1:0] w_cnt;
    logic [NIB_W-1:0] w_idx;
    logic             w_seq_ok;
    logic             w_hdr_ok;
    logic             w_is_hdr;
    logic             w_is_pay;

    assign w_cnt    = i_byte[2*NIB_W-1:NIB_W];
    assign w_idx    = i_byte[NIB_W-1:0];
    assign w_is_hdr = (r_pos == '0);
    assign w_is_pay = !w_is_hdr && (r_pos <= PAY_LAST);
    assign w_seq_ok = (w_idx == '0) ||
                      (r_last_valid && ({1'b0, w_idx} == ({1'b0, r_last_index} + 5'd1)));
    assign w_hdr_ok = (w_cnt != '0) && (w_idx < w_cnt) && w_seq_ok;

    always_comb begin
        n_pos        = r_pos;
        n_accepted   = r_accepted;
        n_last_valid = r_last_valid;
        n_last_index = r_last_index;
        n_addr       = r_addr;
        n_final      = r_final;
        n_len        = r_len;
        if (i_take) begin
            n_pos = (r_pos == FRAME_LAST) ? '0 : r_pos + 1'b1;
            if (w_is_hdr) begin
                n_accepted   = w_hdr_ok;
                n_last_valid = w_hdr_ok;
                n_last_index = w_hdr_ok ? w_idx : '0;
                n_addr       = ADDR_W'(w_idx) * ADDR_W'(PAYLOAD_BYTES);
                n_len        = ADDR_W'(w_cnt) * ADDR_W'(PAYLOAD_BYTES);
                n_final      = ({1'b0, w_idx} + 5'd1) == {1'b0, w_cnt};
            end else if (w_is_pay) begin
                n_addr = r_addr + 1'b1;
            end
        end
    end

    always_comb begin
        o_push = '0;
        if (i_take && w_is_hdr && !w_hdr_ok) begin
            o_push.valid    = 1'b1;
            o_push.res.kind = frd_pkg::KIND_DROP;
        end else if (i_take && w_is_pay && r_accepted) begin
            o_push.valid            = 1'b1;
            o_push.res.kind         = frd_pkg::KIND_WRITE;
            o_push.res.write_addr   = r_addr;
            o_push.res.data_byte    = i_byte;
            o_push.res.message_done = r_final && (r_pos == PAY_LAST);
            o_push.res.message_len  = (r_final && (r_pos == PAY_LAST)) ? r_len : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_accepted   <= 1'b0;
            r_last_valid <= 1'b0;
            r_last_index <= '0;
            r_addr       <= '0;
            r_final      <= 1'b0;
            r_len        <= '0;
        end else begin
            r_pos        <= n_pos;
            r_accepted   <= n_accepted;
            r_last_valid <= n_last_valid;
            r_last_index <= n_last_index;
            r_addr       <= n_addr;
            r_final      <= n_final;
            r_len        <= n_len;
        end
    end

    `FRD_ASSERT_IMPL(a_drop_at_header, i_clk, i_rst_n, o_push.valid && (o_push.res.kind == frd_pkg::KIND_DROP), r_pos == '0)
    `FRD_ASSERT_IMPL(a_done_on_write, i_clk, i_rst_n, o_push.valid && o_push.res.message_done, (o_push.res.kind == frd_pkg::KIND_WRITE) && r_accepted)
    `FRD_ASSERT_NEXT(a_pos_wrap, i_clk, i_rst_n, i_take && (r_pos == FRAME_LAST), r_pos == '0)

endmodule

// ===== sv/frd_outbuf.sv =====
// ----------------------------------------------------------------------------
// frd_outbuf
// two-entry result register decoupling the byte side from the result side
// ----------------------------------------------------------------------------
`include "fragment_reassembly_deframer_macros.svh"

module frd_outbuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  frd_pkg::t_push       i_push,
    output logic                 o_space,
    frd_result_if.source         o_res
);

    localparam logic [1:0] FULL = 2'd2;

    frd_pkg::t_result r_mem [2];
    logic             r_wr, n_wr;
    logic             r_rd, n_rd;
    logic [1:0]       r_count, n_count;
    logic             w_pop;

    assign o_space = (r_count != FULL);
    assign w_pop   = o_res.valid && o_res.ready;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push.valid) begin
            n_wr = !r_wr;
        end
        if (w_pop) begin
            n_rd = !r_rd;
        end
        unique case ({i_push.valid, w_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.res;
        end
    end

    assign o_res.valid        = (r_count != '0);
    assign o_res.kind         = r_mem[r_rd].kind;
    assign o_res.write_addr   = r_mem[r_rd].write_addr;
    assign o_res.data_byte    = r_mem[r_rd].data_byte;
    assign o_res.message_done = r_mem[r_rd].message_done;
    assign o_res.message_len  = r_mem[r_rd].message_len;

    `FRD_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push.valid, r_count != FULL)
    `FRD_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL)

endmodule

// ===== sv/fragment_reassembly_deframer.sv =====
// a result is offered in the cycle after its byte is accepted
// one byte is taken per cycle while the result side keeps taking results
// the two-entry result register lets a byte in while one result waits
// reset: synchronous active low, clears frame position and sequence tracking
// after reset the next byte is taken as a frame header
// ----------------------------------------------------------------------------
// fragment_reassembly_deframer
// splits the fixed-frame byte stream, checks fragment sequence, emits drops and writes
// ----------------------------------------------------------------------------
module fragment_reassembly_deframer #(
    parameter int PAYLOAD_BYTES = frd_pkg::DEF_PAYLOAD_BYTES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    frd_byte_if.sink     i_rx,
    frd_result_if.source o_res
);

    logic           w_space;
    logic           w_take;
    frd_pkg::t_push w_push;

    assign i_rx.ready = w_space;
    assign w_take     = i_rx.valid && w_space;

    frd_ctrl #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_byte  (i_rx.rx_byte),
        .o_push  (w_push)
    );

    frd_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_space (w_space),
        .o_res   (o_res)
    );

endmodule

// ===== test/fragment_reassembly_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// fragment_reassembly_deframer_tb
// Sends 31-byte link frames to the deframer. Directed frames come first:
// header nibble extremes, a zero count, an index at or past the count,
// a skipped fragment, and a payload of 00 and ff bytes.
// Random messages follow, mostly well formed, some broken, some noise,
// then one full-length message that reaches the top addresses.
// Both sides idle at random. A predictor tracks frame position and fragment
// sequence and checks each write or drop request, field by field.
// ----------------------------------------------------------------------------
module fragment_reassembly_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frd_pkg::*;

    localparam int PB           = DEF_PAYLOAD_BYTES;
    localparam int STALL_LIMIT  = 2000;
    localparam int IDLE_PCT     = 34;
    localparam int TOTAL_BYTES  = 650;
    localparam int FULL_FRAGS   = 15;
    localparam int MAX_PRINTS   = 40;

    typedef enum int {
        FILL_RANDOM,
        FILL_EXTREME
    } t_fill;

    typedef struct {
        logic [BYTE_W-1:0] data;
        bit                drain;
    } t_link_byte;

    logic i_clk;
    logic i_rst_n;

    frd_byte_if   rx_if();
    frd_result_if res_if();

    fragment_reassembly_deframer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    t_link_byte link_bytes[$];
    t_result    awaited_results[$];

    int   frame_pos    = 0;
    logic [3:0] cur_index = '0;
    logic [3:0] cur_count = '0;
    bit   frame_ok     = 1'b0;
    bit   seq_valid    = 1'b0;
    logic [3:0] seq_index = '0;

    bit   rx_fire      = 1'b0;
    int   bytes_taken  = 0;
    int   stall_cycles = 0;
    int   err_count    = 0;
    logic quiet;

    assign quiet = (bytes_taken >= 300) && (bytes_taken < 520);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTS) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endtask

    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        t_result r;
        int      off;
        bit      seq_ok;
        r = '0;
        if (frame_pos == 0) begin
            cur_count = b[7:4];
            cur_index = b[3:0];
            seq_ok = (b[3:0] == 4'd0) ||
                     (seq_valid && int'(b[3:0]) == int'(seq_index) + 1);
            if (b[7:4] != 4'd0 && b[3:0] < b[7:4] && seq_ok) begin
                frame_ok  = 1'b1;
                seq_valid = 1'b1;
                seq_index = b[3:0];
            end else begin
                frame_ok  = 1'b0;
                seq_valid = 1'b0;
                seq_index = '0;
                r.kind    = KIND_DROP;
                awaited_results.push_back(r);
            end
        end else if (frame_pos <= PB && frame_ok) begin
            off            = frame_pos - 1;
            r.kind         = KIND_WRITE;
            r.write_addr   = ADDR_W'(PB * int'(cur_index) + off);
            r.data_byte    = b;
            r.message_done = (off == PB - 1) && (int'(cur_index) + 1 == int'(cur_count));
            r.message_len  = r.message_done ? ADDR_W'(int'(cur_count) * PB) : '0;
            awaited_results.push_back(r);
        end
        frame_pos = (frame_pos >= PB + 1) ? 0 : frame_pos + 1;
    endtask

    task automatic check_result();
        t_result exp;
        if (awaited_results.size() == 0) begin
            report("request with nothing awaited");
        end else begin
            exp = awaited_results.pop_front();
            if (res_if.kind !== exp.kind)
                report($sformatf("kind %0d, want %0d", res_if.kind, exp.kind));
            if (res_if.write_addr !== exp.write_addr)
                report($sformatf("write_addr %0d, want %0d", res_if.write_addr,
                                 exp.write_addr));
            if (res_if.data_byte !== exp.data_byte)
                report($sformatf("data_byte %0h, want %0h", res_if.data_byte,
                                 exp.data_byte));
            if (res_if.message_done !== exp.message_done)
                report($sformatf("message_done %0d, want %0d", res_if.message_done,
                                 exp.message_done));
            if (res_if.message_len !== exp.message_len)
                report($sformatf("message_len %0d, want %0d", res_if.message_len,
                                 exp.message_len));
        end
    endtask

    task automatic add_frame(input logic [7:0] hdr, input t_fill fill, input bit drain);
        t_link_byte lb;
        lb.data  = hdr;
        lb.drain = drain;
        link_bytes.push_back(lb);
        lb.drain = 1'b0;
        for (int i = 0; i < PB; i++) begin
            lb.data = (fill == FILL_EXTREME) ? (i[0] ? 8'hff : 8'h00) : 8'($urandom_range(255));
            link_bytes.push_back(lb);
        end
        lb.data = 8'($urandom_range(255));
        link_bytes.push_back(lb);
    endtask

    task automatic add_message(input int cnt, input bit broken, input bit drain);
        int         cut;
        int         pick;
        logic [3:0] idx;
        cut = broken ? $urandom_range(cnt - 1) : -1;
        for (int i = 0; i < cnt; i++) begin
            idx = 4'(i);
            if (i == cut) begin
                pick = $urandom_range(3);
                if (pick == 0) begin
                    // skipped fragment
                    idx = 4'(i + 1 + $urandom_range(2));
                end else if (pick == 1) begin
                    // repeat, or index at the count
                    idx = (i == 0) ? 4'(cnt) : 4'(i - 1);
                end else if (pick == 2) begin
                    idx = 4'(cnt + $urandom_range(15 - cnt));
                end else begin
                    idx = 4'($urandom_range(15));
                end
            end
            add_frame({4'(cnt), idx}, FILL_RANDOM, drain && (i == 0));
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid  <= 1'b0;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            if (!rx_if.valid || rx_fire) begin
                if (link_bytes.size() == 0 ||
                    (link_bytes[0].drain && awaited_results.size() != 0) ||
                    (!quiet && $urandom_range(99) < IDLE_PCT)) begin
                    rx_if.valid <= 1'b0;
                end else begin
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= link_bytes[0].data;
                    void'(link_bytes.pop_front());
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_fire      <= 1'b0;
            stall_cycles <= 0;
        end else begin
            rx_fire <= rx_if.valid && rx_if.ready;
            if (rx_if.valid && rx_if.ready) begin
                deframe_byte(rx_if.rx_byte);
                bytes_taken <= bytes_taken + 1;
            end
            if (res_if.valid && res_if.ready) begin
                check_result();
            end
            if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(negedge i_clk);
        $display("fragment_reassembly_deframer_tb: done, errors");
        $finish;
    end

    initial begin
        int pick;
        int goal;
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready  = 1'b0;

        add_frame(8'h10, FILL_EXTREME, 1'b0);
        add_frame(8'h00, FILL_EXTREME, 1'b0);
        add_frame(8'hff, FILL_RANDOM, 1'b0);
        add_frame(8'h21, FILL_RANDOM, 1'b0);

        goal = TOTAL_BYTES - FULL_FRAGS * (PB + 2);
        while (link_bytes.size() < goal) begin
            pick = $urandom_range(99);
            if (pick < 65)
                add_message($urandom_range(4, 1), 1'b0, $urandom_range(19) == 0);
            else if (pick < 70)
                add_message($urandom_range(8, 5), 1'b0, 1'b0);
            else if (pick < 85)
                add_message($urandom_range(6, 2), 1'b1, 1'b0);
            else
                add_frame(8'($urandom_range(255)), FILL_RANDOM, 1'b0);
        end
        // full-length message reaches the top addresses
        add_message(FULL_FRAGS, 1'b0, 1'b1);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (link_bytes.size() != 0 || rx_if.valid) @(negedge i_clk);
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);

        if (err_count == 0) begin
            $display("fragment_reassembly_deframer_tb: done, clean");
        end else begin
            $display("fragment_reassembly_deframer_tb: done, errors");
        end
        $finish;
    end

endmodule
